// ===== rtl/core/gyro_offset_calibration_macros.svh =====
`ifndef GYRO_OFFSET_CALIBRATION_MACROS_SVH
`define GYRO_OFFSET_CALIBRATION_MACROS_SVH

// check while out of reset
`define GOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check through reset as well
`define GOC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/goc_pkg.sv =====
package goc_pkg;

  localparam int SAMPLE_DEPTH = 3;
  localparam int FILL_W       = $clog2(SAMPLE_DEPTH + 1);

  localparam logic [15:0] STEADY_FACTOR = 16'd3;
  localparam logic [15:0] STEADY_MARGIN = 16'd100;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_WAIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_THR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLACE_WARN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_REP    = 3'd5;

  typedef struct packed {
    logic [15:0] contact_wait;
    logic [15:0] settle;
    logic [11:0] filter_win;
    logic [14:0] zero_thr;
    logic [15:0] place_warn;
    logic [15:0] alert_rep;
  } cfg_t;

  // signed wrapped difference now - t, strictly above limit k
  function automatic logic since_gt(input logic [31:0] now, input logic [31:0] t,
                                    input logic [15:0] k);
    logic [31:0] d;
    d = now - t;
    return !d[31] && (d > {16'd0, k});
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

endpackage

// ===== rtl/core/goc_cfg.sv =====
module goc_cfg
  import goc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.contact_wait <= 16'd3000;
      cfg_r.settle       <= 16'd1000;
      cfg_r.filter_win   <= 12'd333;
      cfg_r.zero_thr     <= 15'd36;
      cfg_r.place_warn   <= 16'd10000;
      cfg_r.alert_rep    <= 16'd15000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CONTACT_WAIT: cfg_r.contact_wait <= cfg_data;
        CFG_SETTLE:       cfg_r.settle       <= cfg_data;
        CFG_FILTER_WIN:   cfg_r.filter_win   <= cfg_data[11:0];
        CFG_ZERO_THR:     cfg_r.zero_thr     <= cfg_data[14:0];
        CFG_PLACE_WARN:   cfg_r.place_warn   <= cfg_data;
        CFG_ALERT_REP:    cfg_r.alert_rep    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/gyro_offset_calibration.sv =====
// Channel | Direction | Ports                         | Carries
// in      | slave     | in_tvalid/in_tready/in_tdata   | one frame tick item
// out     | master    | out_tvalid/out_tready/out_tdata| one result item per tick
// cfg     | write     | cfg_valid/cfg_ready/cfg_index  | register write, cfg_data
//
// One item per cycle unless out_tready stalls; results appear the next cycle.
// The calibration state updates in the same cycle as the item is taken.
// in_tready follows an empty result register or out_tready in that cycle.
// cfg_ready is always high. rst_n is synchronous and restores register defaults.
`include "gyro_offset_calibration_macros.svh"

module gyro_offset_calibration
  import goc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // frame_time[31:0], ground_contact[32], rest_posture[33], player_unstiff[34],
  // imu_time[66:35], gyro_x[82:67], gyro_y[98:83], gyro_z[114:99],
  // steady_since[146:115], zero pad[151:147]
  input  logic [151:0]         in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // offset_x[15:0], offset_y[31:16], offset_z[47:32], imu_bad[48],
  // check_done[49], place_request[50], alert[51], ready_notice[52], zero pad[55:53]
  output logic [55:0]          out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  typedef enum logic [1:0] {PH_WAIT, PH_SAMPLE, PH_SET, PH_OFF} phase_t;

  cfg_t cfg;

  goc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [31:0]        now, imu_time, steady;
  logic               contact, rest, unstiff;
  logic signed [15:0] gx, gy, gz;

  assign now      = in_tdata[31:0];
  assign contact  = in_tdata[32];
  assign rest     = in_tdata[33];
  assign unstiff  = in_tdata[34];
  assign imu_time = in_tdata[66:35];
  assign gx       = in_tdata[82:67];
  assign gy       = in_tdata[98:83];
  assign gz       = in_tdata[114:99];
  assign steady   = in_tdata[146:115];

  phase_t             phase_r, phase_nxt;
  logic [31:0]        first_r, first_nxt;
  logic               had_r, had_nxt;
  logic [31:0]        rest_start_r, rest_start_nxt;
  logic [31:0]        last_smp_r, last_smp_nxt;
  logic [31:0]        place_time_r, place_time_nxt;
  logic [31:0]        alert_time_r, alert_time_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic signed [15:0] rx_r [2];
  logic signed [15:0] ry_r [2];
  logic signed [15:0] rz_r [2];
  logic signed [15:0] rx_nxt [2];
  logic signed [15:0] ry_nxt [2];
  logic signed [15:0] rz_nxt [2];
  logic [15:0]        offx_r, offx_nxt, offy_r, offy_nxt, offz_r, offz_nxt;
  logic               bad_r, bad_nxt, done_r, done_nxt, warned_r, warned_nxt;
  logic               place_nxt, alert_nxt, ready_nxt;
  logic               out_valid_r;
  logic [55:0]        out_data_r;
  logic               take;

  logic [15:0] steady_lim;
  logic [15:0] ax, ay, az;
  logic [15:0] thr16;

  assign steady_lim = 16'(cfg.filter_win) * STEADY_FACTOR + STEADY_MARGIN;
  assign ax         = mag16(rx_r[1]);
  assign ay         = mag16(ry_r[1]);
  assign az         = mag16(rz_r[1]);
  assign thr16      = {1'b0, cfg.zero_thr};

  assign in_tready  = !out_valid_r || out_tready;
  assign take       = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    phase_nxt      = phase_r;
    first_nxt      = first_r;
    had_nxt        = had_r;
    rest_start_nxt = rest_start_r;
    last_smp_nxt   = last_smp_r;
    place_time_nxt = place_time_r;
    alert_time_nxt = alert_time_r;
    fill_nxt       = fill_r;
    rx_nxt         = rx_r;
    ry_nxt         = ry_r;
    rz_nxt         = rz_r;
    offx_nxt       = offx_r;
    offy_nxt       = offy_r;
    offz_nxt       = offz_r;
    bad_nxt        = bad_r;
    done_nxt       = done_r;
    warned_nxt     = warned_r;
    place_nxt      = 1'b0;
    alert_nxt      = 1'b0;
    ready_nxt      = 1'b0;

    if (bad_r && since_gt(now, alert_time_r, cfg.alert_rep)) begin
      alert_time_nxt = now;
      alert_nxt      = 1'b1;
    end

    if (!done_r) begin
      if (first_r == 32'd0 && now != 32'd0) begin
        first_nxt = now;
      end
      if ((first_nxt != 32'd0 && since_gt(now, first_nxt, cfg.contact_wait)) || !unstiff) begin
        had_nxt = had_r || contact || !unstiff;
      end

      if (had_nxt) begin
        case (phase_r)
          PH_WAIT: begin
            if (contact && rest) begin
              if (since_gt(now, rest_start_r, cfg.settle)) begin
                phase_nxt = PH_SAMPLE;
                fill_nxt  = '0;
                rx_nxt    = '{16'sd0, 16'sd0};
                ry_nxt    = '{16'sd0, 16'sd0};
                rz_nxt    = '{16'sd0, 16'sd0};
              end
            end else if (now != 32'd0) begin
              rest_start_nxt = now;
              if (since_gt(now, place_time_r, cfg.place_warn)) begin
                place_time_nxt = now;
                warned_nxt     = 1'b1;
                place_nxt      = 1'b1;
              end
            end
          end
          PH_SAMPLE: begin
            if (!contact) begin
              phase_nxt = PH_WAIT;
            end else begin
              if (since_gt(imu_time, last_smp_r, {4'd0, cfg.filter_win})) begin
                last_smp_nxt = imu_time;
                rx_nxt       = '{gx, rx_r[0]};
                ry_nxt       = '{gy, ry_r[0]};
                rz_nxt       = '{gz, rz_r[0]};
                if (fill_r < FILL_W'(SAMPLE_DEPTH)) begin
                  fill_nxt = fill_r + FILL_W'(1);
                end
              end
              if (fill_nxt >= FILL_W'(SAMPLE_DEPTH)) begin
                phase_nxt = PH_SET;
              end
            end
          end
          PH_SET: begin
            if (since_gt(now, steady, steady_lim)) begin
              offx_nxt = (ax > thr16) ? ax : 16'd0;
              offy_nxt = (ay > thr16) ? ay : 16'd0;
              offz_nxt = (az > thr16) ? az : 16'd0;
              if (ax > thr16 || ay > thr16 || az > thr16) begin
                alert_time_nxt = now;
                alert_nxt      = 1'b1;
                bad_nxt        = 1'b1;
              end
              done_nxt  = 1'b1;
              ready_nxt = warned_r;
              phase_nxt = PH_OFF;
            end else begin
              fill_nxt  = '0;
              rx_nxt    = '{16'sd0, 16'sd0};
              ry_nxt    = '{16'sd0, 16'sd0};
              rz_nxt    = '{16'sd0, 16'sd0};
              phase_nxt = PH_SAMPLE;
              if (since_gt(now, place_time_r, cfg.place_warn)) begin
                place_time_nxt = now;
                warned_nxt     = 1'b1;
                place_nxt      = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      first_r      <= '0;
      had_r        <= 1'b0;
      rest_start_r <= '0;
      last_smp_r   <= '0;
      place_time_r <= '0;
      alert_time_r <= '0;
      fill_r       <= '0;
      rx_r         <= '{16'sd0, 16'sd0};
      ry_r         <= '{16'sd0, 16'sd0};
      rz_r         <= '{16'sd0, 16'sd0};
      offx_r       <= '0;
      offy_r       <= '0;
      offz_r       <= '0;
      bad_r        <= 1'b0;
      done_r       <= 1'b0;
      warned_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        phase_r      <= phase_nxt;
        first_r      <= first_nxt;
        had_r        <= had_nxt;
        rest_start_r <= rest_start_nxt;
        last_smp_r   <= last_smp_nxt;
        place_time_r <= place_time_nxt;
        alert_time_r <= alert_time_nxt;
        fill_r       <= fill_nxt;
        rx_r         <= rx_nxt;
        ry_r         <= ry_nxt;
        rz_r         <= rz_nxt;
        offx_r       <= offx_nxt;
        offy_r       <= offy_nxt;
        offz_r       <= offz_nxt;
        bad_r        <= bad_nxt;
        done_r       <= done_nxt;
        warned_r     <= warned_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
    if (take) begin
      out_data_r <= {3'd0, ready_nxt, alert_nxt, place_nxt, done_nxt, bad_nxt,
                     offz_nxt, offy_nxt, offx_nxt};
    end
  end

  `GOC_ASSERT(a_done_sticky, done_r |=> done_r, "check_done cleared after finishing")
  `GOC_ASSERT(a_bad_done, bad_r |-> done_r, "imu_bad set without finished calibration")
  `GOC_ASSERT(a_off_done, (phase_r == PH_OFF) == done_r, "off phase and check_done disagree")
  `GOC_ASSERT(a_fill_max, fill_r <= FILL_W'(SAMPLE_DEPTH), "sample fill beyond depth")
  `GOC_ASSERT(a_ready_done, out_valid_r && out_data_r[52] |-> out_data_r[49],
              "ready notice without check_done")
  `GOC_ASSERT_RST(a_reset, !rst_n |=> phase_r == PH_WAIT && !out_valid_r && !done_r,
                  "state not cleared by reset")

endmodule
